[rtl/amc_pkg.sv]
`default_nettype none

package amc_pkg;

    localparam int DEF_MAX_SCAN_LEN = 1024;
    localparam int HDR_LEN          = 18;
    localparam int SEQ_W            = 20;
    localparam int RT_W             = 14;
    localparam int ID_W             = 32;

    localparam logic [ID_W-1:0] WILDCARD_ID = 32'h2D2D2D2D;
    localparam logic [23:0]     TAG_NAK     = 24'h4E414B;
    localparam logic [23:0]     TAG_ACK     = 24'h41434B;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_J     = 8'h4A;

    // Configuration register indexes.
    localparam logic CFG_MACHINE_ID = 1'b0;
    localparam logic CFG_REQ_TYPE   = 1'b1;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_SHORT      = 4'd1,
        ST_LENGTH     = 4'd2,
        ST_CHAR       = 4'd3,
        ST_SEQ        = 4'd4,
        ST_REQ_TYPE   = 4'd5,
        ST_NAK_A      = 4'd6,
        ST_NAK_B      = 4'd7,
        ST_NAK_E      = 4'd8,
        ST_NAK_H      = 4'd9,
        ST_NAK_I      = 4'd10,
        ST_NAK_J      = 4'd11,
        ST_ACK_D      = 4'd12,
        ST_BAD_RESULT = 4'd13,
        ST_MACHINE_ID = 4'd14
    } status_t;

    // Summary of one finished message, handed from the tracker to the judge.
    typedef struct packed {
        logic              too_short;
        logic              size_err;
        logic              bad_char;
        logic              seq_ok;
        logic [SEQ_W-1:0]  seq_value;
        logic              rt_neg;
        logic [RT_W-1:0]   rt_value;
        logic [23:0]       result_tag;
        logic [7:0]        code_byte;
        logic [ID_W-1:0]   machine_id;
    } msg_sum_t;

endpackage

`default_nettype wire

[rtl/amc_track.sv]
`default_nettype none

module amc_track
    import amc_pkg::*;
#(
    parameter int MAX_SCAN_LEN = DEF_MAX_SCAN_LEN
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire logic [7:0] msg_byte,
    input  wire logic     last_byte,
    output logic          sum_valid,
    output msg_sum_t      sum,
    input  wire logic     sum_take
);

    localparam int POS_W = $clog2(MAX_SCAN_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SCAN_LEN);
    localparam logic [POS_W-1:0] POS_HDR = POS_W'(HDR_LEN);

    typedef enum logic [2:0] {
        PH_SPACE = 3'b001,
        PH_DIGIT = 3'b010,
        PH_DONE  = 3'b100
    } parse_phase_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= CH_CR));
    endfunction

    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_last_reg;
    logic             s1_move;
    logic             take;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             cr_reg, cr_next;
    logic             np_reg, np_next;
    logic             term_reg, term_next;
    logic             seq_ok_reg, seq_ok_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    parse_phase_t     phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [RT_W-1:0]  rt_reg, rt_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [23:0]      tag_reg, tag_next;
    logic [7:0]       code_reg, code_next;

    logic             sum_valid_reg;
    msg_sum_t         sum_reg;
    logic [3:0]       dval;

    assign s1_move  = s1_valid_reg && (!s1_last_reg || !sum_valid_reg || sum_take);
    assign in_stall = s1_valid_reg && !s1_move;
    assign take     = s1_move && !term_reg && (s1_byte_reg != 8'd0);
    assign dval     = 4'(s1_byte_reg - CH_ZERO);

    always_comb
    begin
        pos_next    = pos_reg;
        cr_next     = cr_reg;
        np_next     = np_reg;
        term_next   = term_reg;
        seq_ok_next = seq_ok_reg;
        seq_next    = seq_reg;
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        rt_next     = rt_reg;
        id_next     = id_reg;
        tag_next    = tag_reg;
        code_next   = code_reg;

        if (s1_move && !term_reg && (s1_byte_reg == 8'd0))
        begin
            term_next = 1'b1;
        end

        if (take)
        begin
            case (pos_reg)
                POS_W'(0):  id_next[31:24] = s1_byte_reg;
                POS_W'(1):  id_next[23:16] = s1_byte_reg;
                POS_W'(2):  id_next[15:8]  = s1_byte_reg;
                POS_W'(3):  id_next[7:0]   = s1_byte_reg;
                POS_W'(4):  tag_next[23:16] = s1_byte_reg;
                POS_W'(5):  tag_next[15:8]  = s1_byte_reg;
                POS_W'(6):  tag_next[7:0]   = s1_byte_reg;
                POS_W'(17): code_next = s1_byte_reg;
                default:    ;
            endcase

            if ((pos_reg >= POS_W'(7)) && (pos_reg < POS_W'(13)))
            begin
                if (is_digit(s1_byte_reg))
                begin
                    seq_next = SEQ_W'(seq_reg * SEQ_W'(10)) + SEQ_W'(dval);
                end
                else
                begin
                    seq_ok_next = 1'b0;
                end
            end

            // Request type: leading white space, one optional sign, then digits.
            if ((pos_reg >= POS_W'(13)) && (pos_reg < POS_W'(17)))
            begin
                case (phase_reg)
                    PH_SPACE:
                    begin
                        if (is_space(s1_byte_reg))
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if ((s1_byte_reg == CH_PLUS) || (s1_byte_reg == CH_MINUS))
                        begin
                            neg_next   = (s1_byte_reg == CH_MINUS);
                            phase_next = PH_DIGIT;
                        end
                        else if (is_digit(s1_byte_reg))
                        begin
                            rt_next    = RT_W'(dval);
                            phase_next = PH_DIGIT;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DIGIT:
                    begin
                        if (is_digit(s1_byte_reg))
                        begin
                            rt_next = RT_W'(rt_reg * RT_W'(10)) + RT_W'(dval);
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE:  phase_next = PH_DONE;
                    default:  phase_next = PH_DONE;
                endcase
            end

            if (!cr_reg && (pos_reg != POS_MAX))
            begin
                if (s1_byte_reg == CH_CR)
                begin
                    cr_next = 1'b1;
                end
                else if ((s1_byte_reg < CH_SPACE) || (s1_byte_reg > CH_TILDE))
                begin
                    np_next = 1'b1;
                end
            end

            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= msg_byte;
            s1_last_reg <= last_byte;
        end
    end

    // Message state returns to its reset value once the last byte has moved on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            cr_reg     <= 1'b0;
            np_reg     <= 1'b0;
            term_reg   <= 1'b0;
            seq_ok_reg <= 1'b1;
            seq_reg    <= '0;
            phase_reg  <= PH_SPACE;
            neg_reg    <= 1'b0;
            rt_reg     <= '0;
        end
        else if (s1_move && s1_last_reg)
        begin
            pos_reg    <= '0;
            cr_reg     <= 1'b0;
            np_reg     <= 1'b0;
            term_reg   <= 1'b0;
            seq_ok_reg <= 1'b1;
            seq_reg    <= '0;
            phase_reg  <= PH_SPACE;
            neg_reg    <= 1'b0;
            rt_reg     <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            cr_reg     <= cr_next;
            np_reg     <= np_next;
            term_reg   <= term_next;
            seq_ok_reg <= seq_ok_next;
            seq_reg    <= seq_next;
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            rt_reg     <= rt_next;
        end
    end

    // Header bytes are only looked at once all eighteen have been written.
    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        tag_reg  <= tag_next;
        code_reg <= code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (s1_move && s1_last_reg)
        begin
            sum_valid_reg <= 1'b1;
        end
        else if (sum_take)
        begin
            sum_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_last_reg)
        begin
            sum_reg.too_short  <= (pos_next < POS_HDR);
            sum_reg.size_err   <= !cr_next && (pos_next == POS_MAX);
            sum_reg.bad_char   <= np_next;
            sum_reg.seq_ok     <= seq_ok_next;
            sum_reg.seq_value  <= seq_next;
            sum_reg.rt_neg     <= neg_next;
            sum_reg.rt_value   <= rt_next;
            sum_reg.result_tag <= tag_next;
            sum_reg.code_byte  <= code_next;
            sum_reg.machine_id <= id_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_MAX)
        else $error("byte position ran past the scan limit");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_last_reg) |=> (pos_reg == '0) && !term_reg && seq_ok_reg)
        else $error("message state not cleared after the last byte");

    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg <= SEQ_W'(999999))
        else $error("sequence accumulator holds more than six digits");

endmodule

`default_nettype wire

[rtl/amc_judge.sv]
`default_nettype none

module amc_judge
    import amc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             sum_valid,
    input  wire msg_sum_t         sum,
    output logic                  sum_take,
    input  wire logic [ID_W-1:0]  exp_machine_id,
    input  wire logic [RT_W-1:0]  exp_req_type,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [3:0]            status_code,
    output logic [SEQ_W-1:0]      sequence_number
);

    logic             out_free;
    status_t          status_next;
    status_t          status_reg;
    logic             out_valid_reg;
    logic [SEQ_W-1:0] seq_out_reg;
    logic             id_bad;

    assign out_free = !out_valid_reg || !out_stall;
    assign sum_take = out_free;
    assign id_bad   = (sum.machine_id != exp_machine_id) && (exp_machine_id != WILDCARD_ID);

    always_comb
    begin
        if (sum.too_short)
        begin
            status_next = ST_SHORT;
        end
        else if (sum.size_err)
        begin
            status_next = ST_LENGTH;
        end
        else if (sum.bad_char)
        begin
            status_next = ST_CHAR;
        end
        else if (!sum.seq_ok)
        begin
            status_next = ST_SEQ;
        end
        else if ((sum.rt_neg && (sum.rt_value != '0)) || (sum.rt_value != exp_req_type))
        begin
            status_next = ST_REQ_TYPE;
        end
        else if (sum.result_tag == TAG_NAK)
        begin
            case (sum.code_byte)
                CH_A:    status_next = ST_NAK_A;
                CH_B:    status_next = ST_NAK_B;
                CH_E:    status_next = ST_NAK_E;
                CH_H:    status_next = ST_NAK_H;
                CH_I:    status_next = ST_NAK_I;
                CH_J:    status_next = id_bad ? ST_MACHINE_ID : ST_NAK_J;
                default: status_next = id_bad ? ST_MACHINE_ID : ST_OK;
            endcase
        end
        else if (sum.result_tag == TAG_ACK)
        begin
            if (id_bad)
            begin
                status_next = ST_MACHINE_ID;
            end
            else if (sum.code_byte == CH_D)
            begin
                status_next = ST_ACK_D;
            end
            else
            begin
                status_next = ST_OK;
            end
        end
        else
        begin
            status_next = ST_BAD_RESULT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && sum_valid)
        begin
            status_reg <= status_next;
            // Sequence output stays zero unless length/char/digits pass.
            if ((status_next == ST_SHORT) || (status_next == ST_LENGTH) ||
                (status_next == ST_CHAR) || (status_next == ST_SEQ))
            begin
                seq_out_reg <= '0;
            end
            else
            begin
                seq_out_reg <= sum.seq_value;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status_code     = status_reg;
    assign sequence_number = seq_out_reg;

    a_early_fail_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((status_reg == ST_SHORT) || (status_reg == ST_LENGTH) ||
                           (status_reg == ST_CHAR) || (status_reg == ST_SEQ)))
        |-> (seq_out_reg == '0))
        else $error("sequence number reported for a message that failed early");

    a_summary_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && out_free) |=> out_valid_reg)
        else $error("accepted summary did not produce a result");

endmodule

`default_nettype wire

[rtl/ack_message_checker.sv]
// A status follows the last byte through the input, summary and output registers.
// Throughput: one byte per cycle unless stalled, set by the message state update.
// A stalled result holds in the output register while the tracker keeps taking bytes
// of the next message; input stalls only when a second finished message is waiting.
// Reset (rst_n, asynchronous, active low) empties the pipeline, clears the message
// state and sets the machine ID to the wildcard and the request type to zero.
`default_nettype none

module ack_message_checker
    import amc_pkg::*;
#(
    parameter int MAX_SCAN_LEN = DEF_MAX_SCAN_LEN
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       msg_byte,
    input  wire logic             last_byte,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [3:0]            status_code,
    output logic [SEQ_W-1:0]      sequence_number,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_index,
    input  wire logic [ID_W-1:0]  cfg_data
);

    logic [ID_W-1:0] machine_id_reg;
    logic [RT_W-1:0] req_type_reg;
    logic            sum_valid;
    logic            sum_take;
    msg_sum_t        sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            machine_id_reg <= WILDCARD_ID;
            req_type_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MACHINE_ID: machine_id_reg <= cfg_data;
                CFG_REQ_TYPE:   req_type_reg   <= cfg_data[RT_W-1:0];
                default:        ;
            endcase
        end
    end

    amc_track #(
        .MAX_SCAN_LEN (MAX_SCAN_LEN)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .msg_byte  (msg_byte),
        .last_byte (last_byte),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_take  (sum_take)
    );

    amc_judge u_judge (
        .clk             (clk),
        .rst_n           (rst_n),
        .sum_valid       (sum_valid),
        .sum             (sum),
        .sum_take        (sum_take),
        .exp_machine_id  (machine_id_reg),
        .exp_req_type    (req_type_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status_code     (status_code),
        .sequence_number (sequence_number)
    );

endmodule

`default_nettype wire

[verif/tb_ack_message_checker.sv]
`default_nettype none

module tb_ack_message_checker;
    import amc_pkg::*;

    localparam int          SETTLE_CYCLES = 6;
    localparam int          RT_MAX        = 9999;
    localparam logic [7:0]  CH_NUL        = 8'h00;
    localparam logic [7:0]  CH_TAB        = 8'h09;
    localparam logic [7:0]  CH_LF         = 8'h0A;
    localparam logic [31:0] ID_HOME       = "M7X2";
    localparam logic [31:0] ID_OTHER      = "M7X3";

    typedef struct packed {
        status_t          status;
        logic [SEQ_W-1:0] seq;
    } ack_verdict_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       msg_byte;
    logic             last_byte;
    logic             out_valid;
    logic             out_stall;
    logic [3:0]       status_code;
    logic [SEQ_W-1:0] sequence_number;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [ID_W-1:0]  cfg_data;

    ack_message_checker dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .msg_byte        (msg_byte),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status_code     (status_code),
        .sequence_number (sequence_number),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Predicted registers and message state.
    logic [ID_W-1:0]  want_machine_id;
    logic [RT_W-1:0]  want_request_type;
    int unsigned      msg_len;
    bit               cr_found;
    bit               bad_char;
    bit               zero_seen;
    bit               seq_digits_ok;
    logic [SEQ_W-1:0] seq_acc;
    logic [7:0]       hdr [HDR_LEN];

    ack_verdict_t     pending_verdicts [$];
    logic [7:0]       frame [$];
    int               fail_count = 0;
    bit               tx_quiet = 1'b0;
    int               rx_hold = 0;
    int               rx_busy = 0;
    int               rx_free = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_ack_message_checker NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    task automatic clear_message_state();
        msg_len       = 0;
        cr_found      = 1'b0;
        bad_char      = 1'b0;
        zero_seen     = 1'b0;
        seq_digits_ok = 1'b1;
        seq_acc       = '0;
        for (int i = 0; i < HDR_LEN; i++)
            hdr[i] = 8'h00;
    endtask

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic status_t grade_message();
        int          k;
        int unsigned val;
        bit          neg;
        status_t     code;
        k = 13;
        val = 0;
        neg = 1'b0;
        code = ST_OK;
        if (msg_len < HDR_LEN)
            return ST_SHORT;
        if (!cr_found && msg_len >= DEF_MAX_SCAN_LEN)
            return ST_LENGTH;
        if (bad_char)
            return ST_CHAR;
        if (!seq_digits_ok)
            return ST_SEQ;
        // The request type field is parsed the way atoi does it.
        while (k < 17 && (hdr[k] == CH_SPACE || (hdr[k] >= CH_TAB && hdr[k] <= CH_CR)))
            k++;
        if (k < 17 && (hdr[k] == CH_PLUS || hdr[k] == CH_MINUS))
        begin
            neg = (hdr[k] == CH_MINUS);
            k++;
        end
        while (k < 17 && is_digit(hdr[k]))
        begin
            val = val * 10 + (hdr[k] - CH_ZERO);
            k++;
        end
        if (neg && val != 0)
            return ST_REQ_TYPE;
        if (val != want_request_type)
            return ST_REQ_TYPE;
        if ({hdr[4], hdr[5], hdr[6]} == TAG_NAK)
        begin
            case (hdr[17])
                CH_A: return ST_NAK_A;
                CH_B: return ST_NAK_B;
                CH_E: return ST_NAK_E;
                CH_H: return ST_NAK_H;
                CH_I: return ST_NAK_I;
                CH_J: code = ST_NAK_J;
                default: ;
            endcase
        end
        else if ({hdr[4], hdr[5], hdr[6]} == TAG_ACK)
        begin
            if (hdr[17] == CH_D)
                code = ST_ACK_D;
        end
        else
            return ST_BAD_RESULT;
        // A machine ID error still wins over NAK J and ACK D.
        if ({hdr[0], hdr[1], hdr[2], hdr[3]} != want_machine_id &&
            want_machine_id != WILDCARD_ID)
            return ST_MACHINE_ID;
        return code;
    endfunction

    task automatic track_message_byte(input logic [7:0] c, input logic fin);
        ack_verdict_t v;
        if (!zero_seen)
        begin
            if (c == CH_NUL)
                zero_seen = 1'b1;
            else
            begin
                if (msg_len < HDR_LEN)
                    hdr[msg_len] = c;
                if (msg_len >= 7 && msg_len < 13)
                begin
                    if (is_digit(c))
                        seq_acc = SEQ_W'(seq_acc * 10 + (c - CH_ZERO));
                    else
                        seq_digits_ok = 1'b0;
                end
                if (!cr_found && msg_len < DEF_MAX_SCAN_LEN)
                begin
                    if (c == CH_CR)
                        cr_found = 1'b1;
                    else if (c < CH_SPACE || c > CH_TILDE)
                        bad_char = 1'b1;
                end
                if (msg_len < DEF_MAX_SCAN_LEN)
                    msg_len++;
            end
        end
        if (fin)
        begin
            v.status = grade_message();
            v.seq = (v.status == ST_OK || v.status >= ST_REQ_TYPE) ? seq_acc : '0;
            pending_verdicts.push_back(v);
            clear_message_state();
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic log_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin : result_checker
        ack_verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
                log_failure($sformatf("unexpected result, status %0d sequence %0d",
                                      status_code, sequence_number));
            else
            begin
                want = pending_verdicts.pop_front();
                if (status_code !== want.status)
                    log_failure($sformatf("status_code expected %0d got %0d",
                                          want.status, status_code));
                if (sequence_number !== want.seq)
                    log_failure($sformatf("sequence_number expected %0d got %0d",
                                          want.seq, sequence_number));
            end
        end
    end

    // ---------------------------------------------------------------- driving

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    // Result receiver: runs of acceptance broken by stalls, plus a long
    // hold-off whenever a test asks for one.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_stall <= 1'b1;
                rx_hold = rx_hold - 1;
            end
            else if (rx_busy > 0)
            begin
                out_stall <= 1'b1;
                rx_busy = rx_busy - 1;
            end
            else if (rx_free > 0)
            begin
                out_stall <= 1'b0;
                rx_free = rx_free - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                rx_busy = pick_gap();
                rx_free = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 120)
                                                       : $urandom_range(0, 6);
            end
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic fin);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        msg_byte  <= c;
        last_byte <= fin;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        track_message_byte(c, fin);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    // Stops offering items and waits until every predicted result is back.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic idx, input logic [ID_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        if (idx == CFG_MACHINE_ID)
            want_machine_id = data;
        else
            want_request_type = data[RT_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- message building

    function automatic logic [7:0] random_printable();
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic logic [31:0] random_id();
        return {random_printable(), random_printable(), random_printable(), random_printable()};
    endfunction

    // Four-character request type field in one of several atoi-friendly layouts.
    function automatic logic [31:0] rt_text(input int unsigned v, input int style);
        logic [7:0] dg [4];
        logic [7:0] t [4];
        logic [7:0] pad;
        int         n;
        dg[0] = CH_ZERO + 8'((v / 1000) % 10);
        dg[1] = CH_ZERO + 8'((v / 100) % 10);
        dg[2] = CH_ZERO + 8'((v / 10) % 10);
        dg[3] = CH_ZERO + 8'(v % 10);
        n = (v >= 1000) ? 4 : (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
        pad = ($urandom_range(0, 6) == 6) ? CH_TAB + 8'($urandom_range(0, 4)) : CH_SPACE;
        t = dg;
        case (style)
            1:
                for (int i = 0; i < 4; i++)
                    t[i] = (i < 4 - n) ? pad : dg[i];
            2:
                if (n <= 3)
                    t[0] = CH_PLUS;
            3:
                for (int i = 0; i < 4; i++)
                    t[i] = (i < n) ? dg[4 - n + i] : (($urandom_range(0, 1) == 1) ?
                                                      CH_SPACE : 8'($urandom_range(65, 90)));
            4:
                if (v == 0)
                begin
                    t[0] = CH_MINUS;
                    t[2] = pad;
                    t[3] = pad;
                end
            default: ;
        endcase
        return {t[0], t[1], t[2], t[3]};
    endfunction

    task automatic build_header(input logic [31:0] id, input logic [23:0] tag,
                                input int unsigned seq, input logic [31:0] rt,
                                input logic [7:0] code, input bit with_crlf);
        int unsigned div;
        logic [7:0]  d;
        frame.delete();
        for (int i = 3; i >= 0; i--)
            frame.push_back(id[i*8 +: 8]);
        for (int i = 2; i >= 0; i--)
            frame.push_back(tag[i*8 +: 8]);
        div = 100000;
        repeat (6)
        begin
            d = CH_ZERO + 8'((seq / div) % 10);
            frame.push_back(d);
            div = div / 10;
        end
        for (int i = 3; i >= 0; i--)
            frame.push_back(rt[i*8 +: 8]);
        frame.push_back(code);
        if (with_crlf)
        begin
            frame.push_back(CH_CR);
            frame.push_back(CH_LF);
        end
    endtask

    task automatic truncate_frame(input int n);
        while (frame.size() > n)
            void'(frame.pop_back());
    endtask

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 7))
            0: return CH_A;
            1: return CH_B;
            2: return CH_D;
            3: return CH_E;
            4: return CH_H;
            5: return CH_I;
            6: return CH_J;
            default: return random_printable();
        endcase
    endfunction

    task automatic random_message();
        int          kind;
        int          r;
        int          idx;
        logic [31:0] id;
        logic [23:0] tag;
        int unsigned rt_val;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            if (want_machine_id != WILDCARD_ID && $urandom_range(0, 9) < 8)
                id = want_machine_id;
            else
                id = ($urandom_range(0, 5) == 0) ? WILDCARD_ID : random_id();
            r = $urandom_range(0, 99);
            tag = (r < 45) ? TAG_ACK : (r < 90) ? TAG_NAK :
                  {random_printable(), random_printable(), random_printable()};
            rt_val = ($urandom_range(0, 9) < 8) ? want_request_type : $urandom_range(0, RT_MAX);
            build_header(id, tag, $urandom_range(0, 999999),
                         rt_text(rt_val, $urandom_range(0, 4)), pick_code(), 1'b0);
            repeat ($urandom_range(0, 4))
                frame.push_back(random_printable());
            if ($urandom_range(0, 9) != 0)
                frame.push_back(CH_CR);
            repeat ($urandom_range(0, 3))
                frame.push_back(8'($urandom_range(0, 255)));
            // Some well-formed messages get one byte broken or are cut short.
            if (kind >= 55)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    idx = $urandom_range(0, frame.size() - 1);
                    frame[idx] = 8'($urandom_range(0, 255));
                end
                else
                    truncate_frame($urandom_range(1, frame.size()));
            end
        end
        else
        begin
            frame.delete();
            repeat ($urandom_range(1, 24))
                frame.push_back(8'($urandom_range(0, 255)));
        end
        tx_quiet = ($urandom_range(0, 9) == 0);
        send_frame();
        tx_quiet = 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_values();
        build_header(random_id(), TAG_ACK, 314159, "0000", CH_D, 1'b1);
        send_frame();
        build_header(random_id(), TAG_ACK, 271828, "0001", CH_D, 1'b1);
        send_frame();
    endtask

    task automatic test_directed_messages();
        logic [7:0] nak_codes [7];
        nak_codes = '{CH_A, CH_B, CH_E, CH_H, CH_I, CH_J, "Q"};
        wait_for_results();
        write_config(CFG_MACHINE_ID, ID_HOME);
        write_config(CFG_REQ_TYPE, 42);

        // Clean ACK whose tail holds the printable limits before the CR.
        build_header(ID_HOME, TAG_ACK, 123, "0042", "Z", 1'b0);
        frame.push_back(CH_SPACE);
        frame.push_back(CH_TILDE);
        frame.push_back(CH_CR);
        send_frame();
        build_header(ID_HOME, TAG_ACK, 999999, "0042", CH_D, 1'b1);
        send_frame();
        for (int i = 0; i < 7; i++)
        begin
            build_header(ID_HOME, TAG_NAK, (i == 6) ? 0 : 5000 + i, "0042", nak_codes[i], 1'b1);
            send_frame();
        end
        // A machine ID error overrides NAK J and ACK D.
        build_header(ID_OTHER, TAG_NAK, 77, "0042", CH_J, 1'b1);
        send_frame();
        build_header(ID_OTHER, TAG_ACK, 78, "0042", CH_D, 1'b1);
        send_frame();
        build_header(ID_HOME, "XYZ", 79, "0042", CH_A, 1'b1);
        send_frame();

        build_header(ID_HOME, TAG_ACK, 80, "\t 42", "Z", 1'b1);
        send_frame();
        build_header(ID_HOME, TAG_ACK, 81, "+042", "Z", 1'b1);
        send_frame();
        build_header(ID_HOME, TAG_ACK, 82, "-042", "Z", 1'b1);
        send_frame();
        build_header(ID_HOME, TAG_ACK, 83, "42ab", "Z", 1'b1);
        send_frame();
        build_header(ID_HOME, TAG_ACK, 84, "0043", "Z", 1'b1);
        send_frame();

        // Non-digit among the sequence digits.
        build_header(ID_HOME, TAG_ACK, 123456, "0042", "Z", 1'b1);
        frame[9] = "a";
        send_frame();
        // Non-printable bytes before the CR.
        build_header(ID_HOME, TAG_ACK, 85, "0042", "Z", 1'b0);
        frame.push_back(8'h7F);
        frame.push_back(CH_CR);
        send_frame();
        build_header(ID_HOME, TAG_ACK, 86, "0042", "Z", 1'b1);
        frame[2] = 8'h1F;
        send_frame();
        // CR as the code byte; the non-printable byte after it is harmless.
        build_header(ID_HOME, TAG_ACK, 87, "0042", CH_CR, 1'b0);
        frame.push_back(8'h80);
        send_frame();

        build_header(ID_HOME, TAG_ACK, 88, "0042", "Z", 1'b1);
        truncate_frame(HDR_LEN - 1);
        send_frame();
        send_byte("A", 1'b1);
        // A zero byte ends the message; what follows up to the last byte is dropped.
        build_header(ID_HOME, TAG_ACK, 89, "0042", "Z", 1'b1);
        frame.push_back(CH_NUL);
        frame.push_back(8'hFF);
        frame.push_back("A");
        send_frame();
        build_header(ID_HOME, TAG_ACK, 90, "0042", "Z", 1'b1);
        frame[10] = CH_NUL;
        send_frame();
        build_header(ID_HOME, TAG_ACK, 91, "0042", "Z", 1'b1);
        frame.push_back(CH_NUL);
        send_frame();
        send_byte(CH_NUL, 1'b1);
    endtask

    task automatic test_config_extremes();
        wait_for_results();
        write_config(CFG_MACHINE_ID, WILDCARD_ID);
        write_config(CFG_REQ_TYPE, RT_MAX);
        build_header("ABCD", TAG_ACK, 92, "9999", "Z", 1'b1);
        send_frame();
        wait_for_results();
        write_config(CFG_REQ_TYPE, 0);
        build_header("----", TAG_ACK, 93, "-0  ", "Z", 1'b1);
        send_frame();
        build_header("WXYZ", TAG_NAK, 94, "    ", CH_J, 1'b1);
        send_frame();
        build_header("WXYZ", TAG_ACK, 95, "+   ", "Z", 1'b1);
        send_frame();
    endtask

    task automatic size_limit_message(input int total, input int cr_pos, input int junk_pos);
        build_header(ID_HOME, TAG_ACK, 96, "0042", "Z", 1'b0);
        while (frame.size() < total)
        begin
            if (frame.size() == cr_pos)
                frame.push_back(CH_CR);
            else if (frame.size() == junk_pos)
                frame.push_back(8'h01);
            else
                frame.push_back(random_printable());
        end
        send_frame();
    endtask

    task automatic test_size_limit();
        wait_for_results();
        write_config(CFG_MACHINE_ID, ID_HOME);
        write_config(CFG_REQ_TYPE, 42);
        size_limit_message(DEF_MAX_SCAN_LEN, -1, -1);
        size_limit_message(DEF_MAX_SCAN_LEN - 1, -1, -1);
        size_limit_message(DEF_MAX_SCAN_LEN, DEF_MAX_SCAN_LEN - 1, -1);
        size_limit_message(DEF_MAX_SCAN_LEN + 80, DEF_MAX_SCAN_LEN, -1);
        size_limit_message(2 * DEF_MAX_SCAN_LEN + 50, -1, DEF_MAX_SCAN_LEN + 10);
    endtask

    // The receiver holds off while short messages keep arriving back to back,
    // so the result side fills up and the input has to stall.
    task automatic test_backpressure();
        wait_for_results();
        rx_hold = 80;
        tx_quiet = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 4 == 3)
                build_header(ID_HOME, TAG_NAK, 1000 + i, "0042", CH_J, 1'b1);
            else
            begin
                frame.delete();
                repeat ($urandom_range(1, 3))
                    frame.push_back(random_printable());
            end
            send_frame();
        end
        tx_quiet = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] rt;
        for (int phase = 0; phase < 5; phase++)
        begin
            wait_for_results();
            case (phase)
                0: begin id = WILDCARD_ID;   rt = $urandom_range(0, RT_MAX); end
                1: begin id = random_id();   rt = 0;                        end
                2: begin id = 32'h0000_0000; rt = RT_MAX;                   end
                3: begin id = 32'hFFFF_FFFF; rt = $urandom_range(0, RT_MAX); end
                default: begin id = random_id(); rt = $urandom_range(0, 99); end
            endcase
            write_config(CFG_MACHINE_ID, id);
            write_config(CFG_REQ_TYPE, rt);
            repeat (14)
                random_message();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        msg_byte  = 8'h00;
        last_byte = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MACHINE_ID;
        cfg_data  = '0;
        want_machine_id   = WILDCARD_ID;
        want_request_type = '0;
        clear_message_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_directed_messages();
        test_config_extremes();
        test_size_limit();
        test_backpressure();
        test_random_traffic();
        wait_for_results();

        if (fail_count == 0)
            $display("tb_ack_message_checker OK");
        else
            $display("tb_ack_message_checker NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/amc_pkg.sv
rtl/amc_track.sv
rtl/amc_judge.sv
rtl/ack_message_checker.sv
verif/tb_ack_message_checker.sv
